[sv/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VNF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define VNF_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/vnf_pkg.sv]
// Package of the value noise height core: item codes, widths and control structs.
// Depends on nothing; the top level and the octave lanes import it.
`default_nettype none

package vnf_pkg;

    // Defaults for the top-level parameters.
    localparam int VNF_TABLE_SIZE = 256;
    localparam int VNF_OCTAVES    = 4;

    // Item kinds carried in tuser. The last code is unused and changes nothing.
    localparam logic [1:0] FUNC_LOAD_VALUE = 2'd0;
    localparam logic [1:0] FUNC_LOAD_PERM  = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE     = 2'd2;
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;

    // Fraction bits of the lattice coordinate.
    localparam int VNF_FRAC = 16;

    // round(0.02 * 2^32) and the width of the coordinate product.
    localparam int          VNF_SCALE_W = 27;
    localparam logic [26:0] VNF_SCALE   = 27'd85899346;
    localparam int          VNF_PW      = 32 + VNF_SCALE_W;

    // Max height register value after reset.
    localparam logic [7:0] VNF_MAX_HEIGHT_RST = 8'd10;

    // Control of one item as it travels down the pipeline.
    typedef struct packed {
        logic        valid;
        logic [1:0]  func;
        logic [7:0]  index;
        logic [15:0] value;
    } ctl_t;

    // Table write enables, one per table copy group.
    typedef struct packed {
        logic perm_a;
        logic perm_b;
        logic value;
    } tbl_we_t;

endpackage

`default_nettype wire

[sv/vnf_ram.sv]
// Table memory with one write port and two registered read ports.
// Depends on nothing; the octave lanes keep several copies of it.
`default_nettype none

module vnf_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr0,
    input  wire logic [AW-1:0]    raddr1,
    output logic      [WIDTH-1:0] rdata0,
    output logic      [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Two read ports; data holds while the pipeline stalls.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

`default_nettype wire

[sv/vnf_octave.sv]
// One octave lane: lattice lookup through replicated tables, smoothstep and lerps.
// Depends on vnf_pkg and vnf_ram.
`default_nettype none

module vnf_octave import vnf_pkg::*; #(
    parameter int TABLE_SIZE = VNF_TABLE_SIZE,
    parameter int OCT_INDEX  = 0,
    localparam int IW        = $clog2(TABLE_SIZE)
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [VNF_PW-1:0] px,
    input  wire logic [VNF_PW-1:0] pz,
    input  wire tbl_we_t           we,
    input  wire logic [IW-1:0]     idx_a,
    input  wire logic [IW-1:0]     idx_b,
    input  wire logic [IW-1:0]     idx_c,
    input  wire logic [7:0]        perm_a,
    input  wire logic [7:0]        perm_b,
    input  wire logic [15:0]       val_c,
    output logic      [15:0]       v
);

    localparam int IP = 2 * VNF_FRAC - OCT_INDEX;
    localparam int FP = VNF_FRAC - OCT_INDEX;

    // Lerp in Q0.16: a * (1 - s) + b * s, floored.
    function automatic logic [15:0] mix(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] s);
        logic [32:0] acc;
        acc = 33'(a) * (33'(17'h10000) - 33'(s)) + 33'(b) * 33'(s);
        return acc[31:16];
    endfunction

    // Cell corners and fractions of this octave.
    logic [IW-1:0] x0, x1, z0, z1;
    logic [15:0]   tx, tz;
    assign x0 = px[IP +: IW];
    assign z0 = pz[IP +: IW];
    assign x1 = x0 + IW'(1);
    assign z1 = z0 + IW'(1);
    assign tx = px[FP +: 16];
    assign tz = pz[FP +: 16];

    // First hash level: perm[x0] and perm[x1].
    logic [7:0] pa0, pa1;
    vnf_ram #(.DEPTH(TABLE_SIZE), .WIDTH(8)) u_perm_a (
        .aclk(aclk), .we(we.perm_a), .waddr(idx_a), .wdata(perm_a), .re(en),
        .raddr0(x0), .raddr1(x1), .rdata0(pa0), .rdata1(pa1)
    );

    // Stage 4 registers: z corners and smoothstep first products.
    logic [IW-1:0] z0_reg, z1_reg;
    logic [31:0]   t2x_reg, t2z_reg;
    logic [17:0]   polyx_reg, polyz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            z0_reg    <= z0;
            z1_reg    <= z1;
            t2x_reg   <= 32'(tx) * 32'(tx);
            t2z_reg   <= 32'(tz) * 32'(tz);
            polyx_reg <= 18'(3 << VNF_FRAC) - 18'({tx, 1'b0});
            polyz_reg <= 18'(3 << VNF_FRAC) - 18'({tz, 1'b0});
        end
    end

    // Second hash level addresses, sums wrap at the table size.
    logic [IW-1:0] h00, h01, h10, h11;
    assign h00 = IW'(pa0) + z0_reg;
    assign h01 = IW'(pa0) + z1_reg;
    assign h10 = IW'(pa1) + z0_reg;
    assign h11 = IW'(pa1) + z1_reg;

    logic [7:0] pb00, pb01, pb10, pb11;
    vnf_ram #(.DEPTH(TABLE_SIZE), .WIDTH(8)) u_perm_b0 (
        .aclk(aclk), .we(we.perm_b), .waddr(idx_b), .wdata(perm_b), .re(en),
        .raddr0(h00), .raddr1(h10), .rdata0(pb00), .rdata1(pb10)
    );
    vnf_ram #(.DEPTH(TABLE_SIZE), .WIDTH(8)) u_perm_b1 (
        .aclk(aclk), .we(we.perm_b), .waddr(idx_b), .wdata(perm_b), .re(en),
        .raddr0(h01), .raddr1(h11), .rdata0(pb01), .rdata1(pb11)
    );

    // Stage 5: finish the smoothstep weights.
    logic [49:0] smx, smz;
    logic [15:0] sx5_reg, sz5_reg;
    assign smx = 50'(t2x_reg) * 50'(polyx_reg);
    assign smz = 50'(t2z_reg) * 50'(polyz_reg);
    always_ff @(posedge aclk) begin
        if (en) begin
            sx5_reg <= smx[47:32];
            sz5_reg <= smz[47:32];
        end
    end

    // Value lookups at the four corners.
    logic [15:0] v00, v01, v10, v11;
    vnf_ram #(.DEPTH(TABLE_SIZE), .WIDTH(16)) u_val0 (
        .aclk(aclk), .we(we.value), .waddr(idx_c), .wdata(val_c), .re(en),
        .raddr0(IW'(pb00)), .raddr1(IW'(pb10)), .rdata0(v00), .rdata1(v10)
    );
    vnf_ram #(.DEPTH(TABLE_SIZE), .WIDTH(16)) u_val1 (
        .aclk(aclk), .we(we.value), .waddr(idx_c), .wdata(val_c), .re(en),
        .raddr0(IW'(pb01)), .raddr1(IW'(pb11)), .rdata0(v01), .rdata1(v11)
    );

    // Stages 6 to 8: weights ride along, then the x lerps and the z lerp.
    logic [15:0] sx6_reg, sz6_reg, sz7_reg, lo_reg, hi_reg, v_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sx6_reg <= sx5_reg;
            sz6_reg <= sz5_reg;
            lo_reg  <= mix(v00, v10, sx6_reg);
            hi_reg  <= mix(v01, v11, sx6_reg);
            sz7_reg <= sz6_reg;
            v_reg   <= mix(lo_reg, hi_reg, sz7_reg);
        end
    end

    assign v = v_reg;

endmodule

`default_nettype wire

[sv/value_noise_fbm_height_core.sv]
// Top level of the fractal value noise terrain height core.
// Depends on vnf_pkg, vnf_octave and vnf_ram.
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------------
//  s_       | in  | tuser: func; tdata: table_index, entry_value, coord_x, coord_z
//  m_       | out | tdata: noise_sum, height
//  cfg_     | in  | data: max_height
//
// One item enters per cycle unless m_ stalls. Depth is set by the two hash levels
// and the value lookup, each a registered memory read, plus the input, absolute
// value, octave sum and output registers and the multiplier stages of scale,
// smoothstep and lerp. Every octave lane keeps its own table copies, written as a
// load passes the stage where that copy is read. Reset clears valid bits and sets
// max_height to 10. A stall on m_ freezes the whole pipeline and drops s_tready.
`default_nettype none

module value_noise_fbm_height_core import vnf_pkg::*; #(
    parameter int TABLE_SIZE = VNF_TABLE_SIZE,
    parameter int OCTAVES    = VNF_OCTAVES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    input  wire logic [87:0] s_tdata,   // [7:0] table_index, [23:8] entry_value,
                                        // [55:24] coord_x, [87:56] coord_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [16:0] noise_sum, [25:17] height, rest zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // [7:0] max_height
);

    localparam int IW   = $clog2(TABLE_SIZE);
    localparam int AW   = 16 + OCTAVES;
    localparam int HW   = 8 + AW;
    localparam int NCTL = 9;

    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Height scale register.
    logic [7:0] max_h_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_h_reg <= VNF_MAX_HEIGHT_RST;
        end else if (cfg_valid) begin
            max_h_reg <= cfg_data;
        end
    end

    // Control pipeline, one entry per stage.
    ctl_t ctl_reg [NCTL];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCTL; i++) begin
                ctl_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            ctl_reg[0] <= '{valid: s_tvalid, func: s_tuser, index: s_tdata[7:0],
                            value: s_tdata[23:8]};
            for (int i = 1; i < NCTL; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Stages 1 to 3: coordinates, absolute values, scale products.
    logic [31:0]       cx_reg, cz_reg, ax_reg, az_reg;
    logic [VNF_PW-1:0] px_reg, pz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg <= s_tdata[55:24];
            cz_reg <= s_tdata[87:56];
            ax_reg <= cx_reg[31] ? (~cx_reg + 32'd1) : cx_reg;
            az_reg <= cz_reg[31] ? (~cz_reg + 32'd1) : cz_reg;
            px_reg <= VNF_PW'(ax_reg) * VNF_PW'(VNF_SCALE);
            pz_reg <= VNF_PW'(az_reg) * VNF_PW'(VNF_SCALE);
        end
    end

    // Table writes, each at the stage where its copies are read.
    tbl_we_t we;
    assign we.perm_a = en && ctl_reg[2].valid && (ctl_reg[2].func == FUNC_LOAD_PERM);
    assign we.perm_b = en && ctl_reg[3].valid && (ctl_reg[3].func == FUNC_LOAD_PERM);
    assign we.value  = en && ctl_reg[4].valid && (ctl_reg[4].func == FUNC_LOAD_VALUE);

    // Octave lanes.
    logic [15:0] v_lane [OCTAVES];
    for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
        vnf_octave #(.TABLE_SIZE(TABLE_SIZE), .OCT_INDEX(k)) u_oct (
            .aclk   (aclk),
            .en     (en),
            .px     (px_reg),
            .pz     (pz_reg),
            .we     (we),
            .idx_a  (IW'(ctl_reg[2].index)),
            .idx_b  (IW'(ctl_reg[3].index)),
            .idx_c  (IW'(ctl_reg[4].index)),
            .perm_a (ctl_reg[2].value[7:0]),
            .perm_b (ctl_reg[3].value[7:0]),
            .val_c  (ctl_reg[4].value),
            .v      (v_lane[k])
        );
    end

    // Stage 9: weighted octave sum.
    logic [AW-1:0] acc_next, acc_reg;
    always_comb begin
        acc_next = '0;
        for (int k = 0; k < OCTAVES; k++) begin
            acc_next = acc_next + (AW'(v_lane[k]) << (OCTAVES - 1 - k));
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_next;
        end
    end

    // Output register: loads and unused codes give zeros.
    logic [HW-1:0] hprod;
    logic [16:0]   noise_sum;
    logic [8:0]    height;
    assign hprod     = HW'(max_h_reg) * HW'(acc_reg);
    assign noise_sum = 17'(acc_reg >> (OCTAVES - 1));
    assign height    = 9'(hprod >> (15 + OCTAVES)) + 9'd1;

    logic [31:0] m_tdata_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ctl_reg[8].valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            if (ctl_reg[8].func == FUNC_SAMPLE) begin
                m_tdata_reg <= {6'd0, height, noise_sum};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[sv/vnf_checker.sv]
// Port-level checker for the value noise height core, bound to the top level.
// Depends on assert_macros.svh and value_noise_fbm_height_core.
`default_nettype none
`include "assert_macros.svh"

module vnf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A result waits until taken and holds its data.
    `VNF_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `VNF_ASSERT_NEXT(a_m_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // A blocked output stops intake.
    `VNF_ASSERT_NOW(a_stall_in, aclk, aresetn, m_tvalid && !m_tready, !s_tready)

    // Height zero marks a load or unused item, never a sample, and its sum is zero.
    `VNF_ASSERT_NOW(a_load_zero, aclk, aresetn, m_tvalid && (m_tdata[25:17] == 9'd0),
                    m_tdata[16:0] == 17'd0)

    // No result is shown right after reset.
    `VNF_ASSERT_RST(a_rst_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind value_noise_fbm_height_core vnf_checker u_vnf_checker (.*);

`default_nettype wire
